// ===== hw/rtl/scba_pkg.sv =====
`timescale 1ns / 1ps
// package for the size-class block allocator
// types, codes, constants and the blocks-per-chunk helper; no dependencies

package scba_pkg;

  localparam int ADDR_W          = 32;
  localparam int SIZE_W          = 32;
  localparam int CLASS_W         = 4;
  localparam int CARVE_W         = 12;
  localparam int CHUNK_CNT_W     = 9;
  localparam int MIN_BLOCK_SHIFT = 6;
  localparam int CHUNK_SHIFT     = 17;
  localparam int CFG_IDX_W       = 1;

  localparam int NUM_CLASSES_DEF = 11;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int MAX_CHUNKS_DEF  = 256;

  localparam logic [ADDR_W-1:0]  MIN_BLOCK = ADDR_W'(64);
  localparam logic [CARVE_W-1:0] CARVE_TOP = CARVE_W'(1 << (CHUNK_SHIFT - MIN_BLOCK_SHIFT));
  localparam logic [CLASS_W-1:0] LAST_CHUNK_CLASS = CLASS_W'(CHUNK_SHIFT - MIN_BLOCK_SHIFT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARENA_BASE   = 1'b0,
    REG_ARENA_CHUNKS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_NO_MEM     = 3'd2,
    ST_STACK_FULL = 3'd3,
    ST_NULL       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIT,
    S_TRY,
    S_PUSH,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   block_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_addr;
    status_t             status;
    logic [CLASS_W-1:0]  class_used;
  } rsp_t;

  // blocks of class c in one chunk, zero for a class larger than a chunk
  function automatic logic [CARVE_W-1:0] blocks_per_chunk(input logic [CLASS_W-1:0] c);
    logic [CARVE_W-1:0] n;
    n = '0;
    if (c <= LAST_CHUNK_CLASS) begin
      n = CARVE_TOP >> c;
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/size_class_block_allocator_core.sv =====
`timescale 1ns / 1ps
// size-class block allocator: sequencer, per-class carve state and free stack memory
// depends on scba_pkg

// One request at a time. An accepted allocate scans the size classes one per cycle
// to find the smallest fit, then tries classes from there upward one per cycle,
// except that taking a fresh chunk makes it try the same class again; a pop from
// the free stack passes through S_POP for the registered memory read, and S_DONE
// writes the result to the output register. An allocate ends on a carve or stack
// hit, or as out of memory after the last class. A too-large request scans every
// class, a free scans to its fit and pushes if the stack has room, a null free ends.
// The free stacks share one memory, with separate read and write addresses, of
// NUM_CLASSES * 2^ceil(log2(STACK_DEPTH)) words; it needs no clearing pass since
// only written entries are ever popped. The input is stalled while a request is in
// flight; a finished result may wait in the output register while the next is worked.

module size_class_block_allocator_core #(
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
  parameter int STACK_DEPTH = scba_pkg::STACK_DEPTH_DEF,
  parameter int MAX_CHUNKS  = scba_pkg::MAX_CHUNKS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [scba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [scba_pkg::ADDR_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  scba_pkg::req_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output scba_pkg::rsp_t                        out_data
);

  import scba_pkg::*;

  localparam int CIW         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW          = $clog2(STACK_DEPTH);
  localparam int SCW         = $clog2(STACK_DEPTH + 1);
  localparam int STACK_SLOTS = 1 << SW;
  localparam int MAW         = CIW + SW;

  state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]       arena_base_r;
  logic [CHUNK_CNT_W-1:0]  arena_chunks_r;
  logic [CHUNK_CNT_W-1:0]  next_chunk_r, next_chunk_nxt;
  logic [CARVE_W-1:0]      carve_left_r [NUM_CLASSES];
  logic [CARVE_W-1:0]      carve_left_nxt [NUM_CLASSES];
  logic [SCW-1:0]          stack_count_r [NUM_CLASSES];
  logic [SCW-1:0]          stack_count_nxt [NUM_CLASSES];
  logic [ADDR_W-1:0]       chunk_addr_r [NUM_CLASSES];

  opcode_t                 op_r, op_nxt;
  logic [SIZE_W-1:0]       size_r, size_nxt;
  logic [ADDR_W-1:0]       baddr_r, baddr_nxt;
  logic [CIW-1:0]          cls_r, cls_nxt;
  logic [CIW-1:0]          fit_r, fit_nxt;
  logic [ADDR_W-1:0]       res_addr_r, res_addr_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic [CLASS_W-1:0]      res_cls_r, res_cls_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rsp_t                    out_data_r, out_data_nxt;

  logic                    chunk_we;
  logic [ADDR_W-1:0]       chunk_wdata;
  logic                    mem_we, mem_re;
  logic [MAW-1:0]          mem_waddr, mem_raddr;
  logic [ADDR_W-1:0]       mem [NUM_CLASSES * STACK_SLOTS];
  logic [ADDR_W-1:0]       rd_data_r;

  logic                    in_fire;
  logic [CARVE_W-1:0]      bpc;
  logic                    chunk_ok;
  logic [CARVE_W-1:0]      carve_dec;
  logic [SCW-1:0]          cnt_dec;
  logic [ADDR_W-1:0]       class_bytes;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bpc         = blocks_per_chunk(CLASS_W'(cls_r));
  assign chunk_ok    = (bpc != '0) && (next_chunk_r < arena_chunks_r) &&
                       (32'(next_chunk_r) < MAX_CHUNKS);
  assign carve_dec   = carve_left_r[cls_r] - CARVE_W'(1);
  assign cnt_dec     = stack_count_r[cls_r] - SCW'(1);
  assign class_bytes = MIN_BLOCK << cls_r;
  assign chunk_wdata = arena_base_r + (ADDR_W'(next_chunk_r) << CHUNK_SHIFT);

  always_comb begin
    state_nxt       = state_r;
    next_chunk_nxt  = next_chunk_r;
    carve_left_nxt  = carve_left_r;
    stack_count_nxt = stack_count_r;
    op_nxt          = op_r;
    size_nxt        = size_r;
    baddr_nxt       = baddr_r;
    cls_nxt         = cls_r;
    fit_nxt         = fit_r;
    res_addr_nxt    = res_addr_r;
    res_status_nxt  = res_status_r;
    res_cls_nxt     = res_cls_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    chunk_we        = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = {cls_r, stack_count_r[cls_r][SW-1:0]};
    mem_raddr       = {cls_r, cnt_dec[SW-1:0]};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_data.opcode;
          size_nxt       = in_data.req_size;
          baddr_nxt      = in_data.block_addr;
          cls_nxt        = '0;
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          res_cls_nxt    = '0;
          if (in_data.opcode == OP_FREE && in_data.block_addr == '0) begin
            res_status_nxt = ST_NULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FIT;
          end
        end
      end
      S_FIT: begin
        if (size_r <= class_bytes) begin
          fit_nxt     = cls_r;
          res_cls_nxt = CLASS_W'(cls_r);
          state_nxt   = (op_r == OP_FREE) ? S_PUSH : S_TRY;
        end else if (cls_r == CIW'(NUM_CLASSES - 1)) begin
          res_status_nxt = ST_TOO_LARGE;
          state_nxt      = S_DONE;
        end else begin
          cls_nxt = cls_r + CIW'(1);
        end
      end
      S_TRY: begin
        if (stack_count_r[cls_r] != '0) begin
          stack_count_nxt[cls_r] = cnt_dec;
          mem_re                 = 1'b1;
          res_cls_nxt            = CLASS_W'(cls_r);
          state_nxt              = S_POP;
        end else if (carve_left_r[cls_r] != '0) begin
          carve_left_nxt[cls_r] = carve_dec;
          res_addr_nxt = chunk_addr_r[cls_r] + ((ADDR_W'(carve_dec) << cls_r) << MIN_BLOCK_SHIFT);
          res_cls_nxt  = CLASS_W'(cls_r);
          state_nxt    = S_DONE;
        end else if (chunk_ok) begin
          chunk_we              = 1'b1;
          carve_left_nxt[cls_r] = bpc;
          next_chunk_nxt        = next_chunk_r + CHUNK_CNT_W'(1);
        end else if (cls_r == CIW'(NUM_CLASSES - 1)) begin
          res_status_nxt = ST_NO_MEM;
          res_cls_nxt    = CLASS_W'(fit_r);
          state_nxt      = S_DONE;
        end else begin
          cls_nxt = cls_r + CIW'(1);
        end
      end
      S_POP: begin
        res_addr_nxt = rd_data_r;
        state_nxt    = S_DONE;
      end
      S_PUSH: begin
        if (stack_count_r[cls_r] >= SCW'(STACK_DEPTH)) begin
          res_status_nxt = ST_STACK_FULL;
        end else begin
          mem_we                 = 1'b1;
          stack_count_nxt[cls_r] = stack_count_r[cls_r] + SCW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result_addr = res_addr_r;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.class_used  = res_cls_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      arena_base_r   <= '0;
      arena_chunks_r <= '0;
      next_chunk_r   <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        carve_left_r[i]  <= '0;
        stack_count_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      next_chunk_r  <= next_chunk_nxt;
      out_valid_r   <= out_valid_nxt;
      carve_left_r  <= carve_left_nxt;
      stack_count_r <= stack_count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ARENA_BASE:   arena_base_r   <= cfg_data;
          REG_ARENA_CHUNKS: arena_chunks_r <= cfg_data[CHUNK_CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    size_r       <= size_nxt;
    baddr_r      <= baddr_nxt;
    cls_r        <= cls_nxt;
    fit_r        <= fit_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    res_cls_r    <= res_cls_nxt;
    out_data_r   <= out_data_nxt;
    if (chunk_we) begin
      chunk_addr_r[cls_r] <= chunk_wdata;
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= baddr_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input not stalled after accepted transaction");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented outside done state");

  a_pop_after_try: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> $past(state_r == S_TRY) && $past(mem_re))
    else $error("stack pop without memory read");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |=> stack_count_r[$past(cls_r)] <= SCW'(STACK_DEPTH))
    else $error("free stack count beyond depth");
`endif

endmodule
